// ----- rtl/core/itrd_pkg.sv -----
// Package for the integer to radix digit converter.
// Holds field widths, character constants, the cell control struct and the
// digit to ASCII mapping. No dependencies.
package itrd_pkg;

  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN      = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX      = RADIX_W'(36);
  localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = DIGIT_W'(10);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO      = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  CHAR_A         = CHAR_W'(65);

  typedef logic [RADIX_W-1:0] radix_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [CHAR_W-1:0]  char_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

  function automatic char_t digit_to_char(input digit_t d);
    char_t c;
    if (d < DECIMAL_DIGITS) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A + CHAR_W'(d - DECIMAL_DIGITS);
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/itrd_if.sv -----
// Valid/ready channel interfaces for the integer to radix digit converter.
// Depends on itrd_pkg for the radix and character types.
interface itrd_in_if #(parameter int VALUE_BITS = 31);
  logic                   valid;
  logic                   ready;
  logic [VALUE_BITS-1:0]  value;
  itrd_pkg::radix_t       radix;
  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

interface itrd_out_if;
  logic            valid;
  logic            ready;
  itrd_pkg::char_t digit_char;
  logic            last_digit;
  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

// ----- rtl/core/itrd_cell.sv -----
// One digit cell of the conversion chain: doubles its digit and adds the
// carry from below, reduces modulo the radix, and passes the carry upward.
// Depends on itrd_pkg.
module itrd_cell (
  input  logic                clk,
  input  logic                rst,
  input  itrd_pkg::cell_ctl_t ctl,
  input  itrd_pkg::radix_t    radix,
  input  logic                carry_in,
  input  logic                step_in,
  input  itrd_pkg::digit_t    digit_in,
  output logic                carry_out,
  output logic                step_out,
  output itrd_pkg::digit_t    digit
);
  import itrd_pkg::*;

  logic [DIGIT_W:0] sum;
  logic [DIGIT_W:0] diff;
  logic             ge;
  digit_t           digit_next;

  assign sum        = {digit, carry_in};
  assign diff       = sum - {1'b0, radix};
  assign ge         = sum >= {1'b0, radix};
  assign digit_next = ge ? diff[DIGIT_W-1:0] : sum[DIGIT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      step_out <= 1'b0;
    end else if (ctl.clear) begin
      step_out <= 1'b0;
    end else begin
      step_out <= step_in;
    end

    if (ctl.clear) begin
      digit     <= '0;
      carry_out <= 1'b0;
    end else if (ctl.shift) begin
      digit <= digit_in;
    end else if (step_in) begin
      digit     <= digit_next;
      carry_out <= ge;
    end
  end

endmodule

// ----- rtl/core/integer_to_radix_digits.sv -----
// Top level of the integer to radix digit converter: input control, the
// chain of digit cells and the character output register.
// Depends on itrd_pkg, itrd_if and itrd_cell.
//
//  channel  dir  payload                        beat
//  items    in   value[VALUE_BITS], radix[6]    one integer to convert
//  chars    out  digit_char[7], last_digit      one ASCII digit, MSD first
//
// Each beat is converted as the carry wavefront skews through the cell
// chain, then the cells are shifted out, leading zeros dropped one a cycle.
// Stalls on the output only lengthen the shift-out phase.
// Reset is synchronous and clears control state; the digits need none.
module integer_to_radix_digits #(
  parameter int VALUE_BITS = 31,
  parameter int MAX_DIGITS = 32
) (
  input logic clk,
  input logic rst,
  itrd_in_if.sink    items,
  itrd_out_if.source chars
);
  import itrd_pkg::*;

  localparam int CONV_CYCLES = VALUE_BITS + MAX_DIGITS - 1;
  localparam int TW          = $clog2(CONV_CYCLES + 1);
  localparam int RW          = $clog2(MAX_DIGITS + 1);

  typedef enum logic [1:0] {IDLE, CONV, EMIT} state_t;

  state_t                state;
  logic [TW-1:0]         tick;
  logic [RW-1:0]         remaining;
  logic                  started;
  logic [VALUE_BITS-1:0] value_sr;
  radix_t                radix;
  radix_t                radix_sat;
  logic                  out_valid;
  char_t                 out_char;
  logic                  out_last;

  cell_ctl_t cell_ctl;
  logic      carry [MAX_DIGITS+1];
  logic      step  [MAX_DIGITS+1];
  digit_t    digits [MAX_DIGITS+1];

  logic accept;
  logic out_free;
  logic skip;
  logic emit;
  logic at_last;
  digit_t top_digit;

  assign items.ready = (state == IDLE);
  assign accept      = items.valid && items.ready;
  assign out_free    = !out_valid || chars.ready;
  assign top_digit   = digits[MAX_DIGITS];
  assign at_last     = (remaining == RW'(1));
  assign skip        = (state == EMIT) && (top_digit == '0) && !started && !at_last;
  assign emit        = (state == EMIT) && !skip && out_free;

  always_comb begin
    if (items.radix < RADIX_MIN) begin
      radix_sat = RADIX_MIN;
    end else if (items.radix > RADIX_MAX) begin
      radix_sat = RADIX_MAX;
    end else begin
      radix_sat = items.radix;
    end
  end

  assign cell_ctl.clear = accept;
  assign cell_ctl.shift = skip || emit;

  assign carry[0]  = value_sr[VALUE_BITS-1];
  assign step[0]   = (state == CONV) && (tick < TW'(VALUE_BITS));
  assign digits[0] = '0;

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
    itrd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (cell_ctl),
      .radix     (radix),
      .carry_in  (carry[i]),
      .step_in   (step[i]),
      .digit_in  (digits[i]),
      .carry_out (carry[i+1]),
      .step_out  (step[i+1]),
      .digit     (digits[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      tick      <= '0;
      remaining <= '0;
      started   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (chars.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            tick  <= '0;
            state <= CONV;
          end
        end
        CONV: begin
          tick <= tick + TW'(1);
          if (tick == TW'(CONV_CYCLES - 1)) begin
            remaining <= RW'(MAX_DIGITS);
            started   <= 1'b0;
            state     <= EMIT;
          end
        end
        EMIT: begin
          if (skip || emit) begin
            remaining <= remaining - RW'(1);
          end
          if (emit) begin
            started <= 1'b1;
            if (at_last) begin
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end

    if (accept) begin
      value_sr <= items.value;
      radix    <= radix_sat;
    end else if (step[0]) begin
      value_sr <= {value_sr[VALUE_BITS-2:0], 1'b0};
    end

    if (emit) begin
      out_char <= digit_to_char(top_digit);
      out_last <= at_last;
    end
  end

  assign chars.valid      = out_valid;
  assign chars.digit_char = out_char;
  assign chars.last_digit = out_last;

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    emit && at_last |=> (state == IDLE) && out_last)
    else $error("Final digit did not end the item.");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_char >= CHAR_ZERO && out_char <= CHAR_ZERO + CHAR_W'(9)) ||
                  (out_char >= CHAR_A && out_char <= CHAR_A + CHAR_W'(25)))
    else $error("Output character outside the digit set.");

  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    (state == EMIT) |-> (remaining != '0))
    else $error("Shift-out ran past the last cell.");

  a_shift_only_emit: assert property (@(posedge clk) disable iff (rst)
    cell_ctl.shift |-> (state == EMIT) && !step[MAX_DIGITS-1])
    else $error("Cells shifted while a conversion was in flight.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !chars.ready |=> out_valid && $stable(out_char))
    else $error("Pending character was overwritten.");

endmodule
